// File: hdl/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define FFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked also during reset
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    localparam int MAX_CELLS = 128;
    localparam int ID_WIDTH  = 16;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int FIELD_W   = 16;
    localparam int CFG_W     = 8;

    localparam logic [ID_WIDTH-1:0] ID_ALL_ONES = '1;
    localparam logic [ID_WIDTH-1:0] ID_FIRST    = ID_WIDTH'(1);

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_DEFRAG = 2'd2;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NULL      = 2'd1;
    localparam logic [1:0] ST_ILLEGAL   = 2'd2;

    typedef struct packed {
        logic       start;
        logic       scan;
        logic       fill;
        logic       clear;
        logic       load_out;
        logic [1:0] res_code;
    } ffba_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       alloc_bad;
        logic       hit;
        logic       scan_done;
        logic       found;
        logic       fill_last;
        logic       clear_done;
        logic       out_full;
    } ffba_stat_t;
endpackage
`default_nettype wire

// File: hdl/first_fit_block_allocator.sv
// First-fit block allocator, top level: joins controller and datapath.
// Depends on ffba_pkg, ffba_ctrl, ffba_dp.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. Alloc and erase scan the active cells through the
// cell RAM read port, one cell a cycle; a successful alloc then fills its
// block. Defragment takes one scan plus one cycle per cleared tail cell.
// Alloc with a zero or oversized length, or with the id counter saturated,
// answers without a scan. Cells are cleared at reset by per-cell valid bits,
// no clearing pass.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic [FIELD_W-1:0] argument,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [FIELD_W-1:0]      block_id,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   memory_size
);
    ffba_cmd_t  cmd;
    ffba_stat_t st;

    assign cfg_ready = 1'b1;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .action    (action),
        .argument  (argument),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (memory_size),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .block_id  (block_id)
    );
endmodule
`default_nettype wire

// File: hdl/ffba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/ffba_ctrl.sv
// Controller of the first-fit block allocator: sequences scan, fill, clear, result.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ffba_stat_t st,
    output ffba_cmd_t       cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_NULL;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.res_code = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (st.act == ACT_ALLOC && st.alloc_bad)
                begin
                    code_next  = ST_NULL;
                    state_next = S_RESULT;
                end
                else if (st.hit)
                begin
                    state_next = S_FILL;
                end
                else if (st.scan_done)
                begin
                    priority if (st.act == ACT_ALLOC)
                    begin
                        code_next  = ST_NULL;
                        state_next = S_RESULT;
                    end
                    else if (st.act == ACT_ERASE)
                    begin
                        code_next  = ST_ILLEGAL;
                        state_next = st.found ? S_IDLE : S_RESULT;
                    end
                    else if (st.act == ACT_DEFRAG)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (st.act == ACT_ALLOC || st.act == ACT_ERASE
                         || st.act == ACT_DEFRAG)
                begin
                    cmd.scan = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;  // unused action code
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (st.fill_last)
                begin
                    code_next  = ST_ALLOCATED;
                    state_next = S_RESULT;
                end
            end
            S_CLEAR:
            begin
                if (st.clear_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clear = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (!st.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/ffba_dp.sv
// Datapath of the first-fit block allocator: cell RAM, valid bits, scan and
// write pointers, id counter, size register and result register.
// Depends on ffba_pkg, ffba_ram and first_fit_block_allocator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module ffba_dp
    import ffba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ffba_cmd_t          cmd,
    output ffba_stat_t              st,
    input  wire logic [1:0]         action,
    input  wire logic [FIELD_W-1:0] argument,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [FIELD_W-1:0]      block_id
);
    logic [CFG_W-1:0]    size_cfg_reg;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [1:0]          act_reg;
    logic [FIELD_W-1:0]  arg_reg;
    logic [MAX_CELLS-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                pv_reg, pv_next;
    logic [ADDR_W-1:0]   pidx_reg, pidx_next;
    logic                rvld_reg, rvld_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic                hit_reg, hit_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic [ADDR_W-1:0]   fptr_reg, fptr_next, fend_reg, fend_next;
    logic                ov_reg, ov_next;
    logic [1:0]          st_out_reg;
    logic [FIELD_W-1:0]  id_out_reg;

    logic [CNT_W-1:0]    size;
    logic                rd_en;
    logic [ADDR_W-1:0]   raddr;
    logic [ID_WIDTH-1:0] rdata, cur_owner;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [CNT_W-1:0]    run_inc;

    assign size = (int'(size_cfg_reg) > MAX_CELLS) ? CNT_W'(MAX_CELLS)
                                                    : CNT_W'(size_cfg_reg);
    assign cur_owner = rvld_reg ? rdata : '0;
    assign run_inc   = run_reg + CNT_W'(1);
    assign raddr     = rd_cnt_reg[ADDR_W-1:0];

    ffba_ram #(.WIDTH(ID_WIDTH), .DEPTH(MAX_CELLS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        rvld_next   = rvld_reg;
        run_next    = run_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        w_next      = w_reg;
        fptr_next   = fptr_reg;
        fend_next   = fend_reg;
        vld_next    = vld_reg;
        id_next     = id_reg;
        ov_next     = ov_reg && !out_ready;
        rd_en       = 1'b0;
        we          = 1'b0;
        waddr       = fptr_reg;
        wdata       = id_reg;
        if (cmd.start)
        begin
            rd_cnt_next = '0;
            run_next    = '0;
            hit_next    = 1'b0;
            found_next  = 1'b0;
            w_next      = '0;
        end
        if (cmd.scan)
        begin
            if (rd_cnt_reg < size)
            begin
                rd_en       = 1'b1;
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                pv_next     = 1'b1;
                pidx_next   = raddr;
                rvld_next   = vld_reg[raddr];
            end
            if (pv_reg)
            begin
                priority if (act_reg == ACT_ALLOC)
                begin
                    if (cur_owner != '0)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                        if (32'(run_inc) == 32'(arg_reg))
                        begin
                            hit_next  = 1'b1;
                            pv_next   = 1'b0;
                            fend_next = pidx_reg;
                            fptr_next = ADDR_W'(CNT_W'(pidx_reg) + CNT_W'(1) - run_inc);
                        end
                    end
                end
                else if (act_reg == ACT_ERASE)
                begin
                    if (arg_reg != '0 && 32'(cur_owner) == 32'(arg_reg))
                    begin
                        vld_next[pidx_reg] = 1'b0;
                        found_next         = 1'b1;
                    end
                end
                else
                begin
                    // compaction: write index always trails the read index
                    if (cur_owner != '0)
                    begin
                        we     = 1'b1;
                        waddr  = w_reg[ADDR_W-1:0];
                        wdata  = cur_owner;
                        vld_next[w_reg[ADDR_W-1:0]] = 1'b1;
                        w_next = w_reg + CNT_W'(1);
                    end
                end
            end
        end
        if (cmd.fill)
        begin
            we        = 1'b1;
            waddr     = fptr_reg;
            wdata     = id_reg;
            vld_next[fptr_reg] = 1'b1;
            fptr_next = fptr_reg + ADDR_W'(1);
        end
        if (cmd.clear)
        begin
            vld_next[w_reg[ADDR_W-1:0]] = 1'b0;
            w_next = w_reg + CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            ov_next = 1'b1;
            if (cmd.res_code == ST_ALLOCATED)
            begin
                id_next = id_reg + ID_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= CFG_W'(100);
            id_reg       <= ID_FIRST;
            vld_reg      <= '0;
            rd_cnt_reg   <= '0;
            pv_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            found_reg    <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_cfg_reg <= cfg_data;
            end
            id_reg     <= id_next;
            vld_reg    <= vld_next;
            rd_cnt_reg <= rd_cnt_next;
            pv_reg     <= pv_next;
            hit_reg    <= hit_next;
            found_reg  <= found_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        rvld_reg <= rvld_next;
        run_reg  <= run_next;
        w_reg    <= w_next;
        fptr_reg <= fptr_next;
        fend_reg <= fend_next;
        if (cmd.start)
        begin
            act_reg <= action;
            arg_reg <= argument;
        end
        if (cmd.load_out)
        begin
            st_out_reg <= cmd.res_code;
            id_out_reg <= (cmd.res_code == ST_ALLOCATED) ? FIELD_W'(id_reg) : '0;
        end
    end

    assign out_valid = ov_reg;
    assign status    = st_out_reg;
    assign block_id  = id_out_reg;

    assign st.act        = act_reg;
    assign st.alloc_bad  = (arg_reg == '0) || (32'(arg_reg) > 32'(size))
                           || (id_reg >= ID_ALL_ONES);
    assign st.hit        = hit_reg;
    assign st.scan_done  = !pv_reg && (rd_cnt_reg >= size);
    assign st.found      = found_reg;
    assign st.fill_last  = (fptr_reg == fend_reg);
    assign st.clear_done = (w_reg >= size);
    assign st.out_full   = ov_reg && !out_ready;

    `FFBA_ASSERT(a_no_rw_clash, (we && rd_en) |-> (waddr != raddr), "write hits read address")
    `FFBA_ASSERT(a_hit_alloc, hit_reg |-> (act_reg == ACT_ALLOC), "hit outside alloc")
    `FFBA_ASSERT(a_fill_range, cmd.fill |-> (fptr_reg <= fend_reg), "fill past block end")
endmodule
`default_nettype wire
